// ----- rtl/core/imsi_pkg.sv -----
// Shared constants and types for the IMU motion segment integrator.
package imsi_pkg;

  localparam int WINDOW_LEN = 11;
  localparam int FILL_W     = $clog2(WINDOW_LEN + 1);
  localparam int WIN_AW     = $clog2(WINDOW_LEN);
  localparam int SAMPLE_W   = 16;
  localparam int NCH        = 6;
  localparam int CH_W       = 3;
  localparam int SUM_W      = SAMPLE_W + FILL_W;
  localparam int SQ_W       = 31 + FILL_W;
  localparam int NN_W       = 2 * FILL_W;
  localparam int SUMS_W     = SUM_W + SQ_W;
  localparam int WIN_W      = NCH * SAMPLE_W;
  localparam int MUL_A_W    = SQ_W + 1;
  localparam int MUL_B_W    = SUM_W;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int VAL_W      = 48;
  localparam int IDX_W      = 24;
  localparam int PADDR_W    = 4;

  localparam logic [31:0] ACC_THR_RESET  = 32'd15099;
  localparam logic [31:0] GYRO_THR_RESET = 32'd503316;
  localparam logic [15:0] PERIOD_RESET   = 16'd3277;
  localparam logic [15:0] GRAVITY_RESET  = 16'd40223;

  typedef enum logic [1:0] {
    REG_ACC_THR  = 2'd0,
    REG_GYRO_THR = 2'd1,
    REG_PERIOD   = 2'd2,
    REG_GRAVITY  = 2'd3
  } reg_idx_t;

endpackage

// ----- rtl/core/imsi_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module imsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/imu_motion_segment_integrator.sv -----
// Top level of the IMU motion segment integrator.
//
// Input channel: one six-axis sample per item (in_valid/in_ready), Q3.12,
// with final_sample marking the last sample of a recording. Output channel
// (out_valid/out_ready): segment results, and after a final sample the
// grand totals; last_result flags the last result caused by an input item.
// Configuration goes through the APB port: thresholds, sample period and
// gravity scale, to be written only while the block is idle; the block
// itself does not enforce this. Each item is handled alone by a sequencer
// around one shared 36x20 multiplier, a window RAM and a RAM of per-channel
// sums. Ingest updates the sums of each channel in turn; deciding a
// sample tests each channel's variance against its threshold and, when a
// segment is open, integrates the three axes. A final item repeats the
// decision once per held sample and then emits the totals.
// Results pass through one output register, so the block takes the next
// item while a result waits; a stalled receiver holds the sequencer only
// when a further result must be emitted. Reset is synchronous and returns
// the registers to their defaults and the recording to empty at once.
module imu_motion_segment_integrator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [imsi_pkg::PADDR_W-1:0]       paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [15:0]                 acc_x,
  input  logic signed [15:0]                 acc_y,
  input  logic signed [15:0]                 acc_z,
  input  logic signed [15:0]                 pitch_rate,
  input  logic signed [15:0]                 roll_rate,
  input  logic signed [15:0]                 yaw_rate,
  input  logic                               final_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               is_total,
  output logic [imsi_pkg::IDX_W-1:0]         seg_start,
  output logic [imsi_pkg::IDX_W-1:0]         seg_stop,
  output logic signed [imsi_pkg::VAL_W-1:0]  pitch_angle,
  output logic signed [imsi_pkg::VAL_W-1:0]  roll_angle,
  output logic signed [imsi_pkg::VAL_W-1:0]  yaw_angle,
  output logic signed [imsi_pkg::VAL_W-1:0]  disp_x,
  output logic signed [imsi_pkg::VAL_W-1:0]  disp_y,
  output logic signed [imsi_pkg::VAL_W-1:0]  disp_z,
  output logic                               last_result
);

  localparam int VW = imsi_pkg::VAL_W;
  localparam int XW = imsi_pkg::VAL_W + 3;
  localparam logic signed [XW-1:0] SAT_HI = (XW'(1) <<< (VW - 1)) - XW'(1);
  localparam logic signed [XW-1:0] SAT_LO = -(XW'(1) <<< (VW - 1));

  typedef enum logic [4:0] {
    S_IDLE, S_I_RD, S_I_SQ, S_I_WR,
    S_D_RD, S_D_X, S_C_RD, S_C_SS, S_C_NQ, S_C_TH, S_C_XX, S_C_WB,
    S_D_SEG, S_G_ANG, S_G_ACC, S_G_ADT, S_G_VEL, S_G_HI, S_G_LO, S_G_DSP,
    S_D_CLOSE, S_D_END, S_TOT
  } state_t;

  function automatic logic signed [VW-1:0] sat48(input logic signed [XW-1:0] x);
    logic signed [VW-1:0] r;
    if (x > SAT_HI) r = SAT_HI[VW-1:0];
    else if (x < SAT_LO) r = SAT_LO[VW-1:0];
    else r = x[VW-1:0];
    return r;
  endfunction

  // Configuration registers.
  logic [31:0] acc_thr, gyro_thr;
  logic [15:0] period, gravity;

  state_t state;
  logic [imsi_pkg::CH_W-1:0]   ch;
  logic [1:0]                  ax;
  logic [imsi_pkg::FILL_W-1:0] fill;
  logic [imsi_pkg::WIN_AW-1:0] head;
  logic [imsi_pkg::IDX_W-1:0]  counter, seg_begin;
  logic                        active, moving, fin;
  logic [imsi_pkg::NCH-1:0]    sum_vld;

  logic signed [15:0] vin [imsi_pkg::NCH];
  logic signed [15:0] xs  [imsi_pkg::NCH];

  logic signed [imsi_pkg::SUM_W-1:0]   cur_sum;
  logic [imsi_pkg::SQ_W-1:0]           cur_sq;
  logic [imsi_pkg::NN_W-1:0]           nn;
  logic signed [imsi_pkg::MUL_P_W-1:0] t_ssq, t_nsq;
  logic signed [VW-1:0]                hi_p;
  logic signed [VW:0]                  vsum;

  logic signed [VW-1:0] angle [3];
  logic signed [VW-1:0] vel   [3];
  logic signed [VW-1:0] disp  [3];
  logic signed [VW-1:0] grand [imsi_pkg::NCH];

  logic signed [imsi_pkg::MUL_A_W-1:0] mul_a;
  logic signed [imsi_pkg::MUL_B_W-1:0] mul_b;
  logic signed [imsi_pkg::MUL_P_W-1:0] mul_p;

  // RAM ports.
  logic                          win_we;
  logic [imsi_pkg::WIN_AW-1:0]   win_waddr;
  logic [imsi_pkg::WIN_W-1:0]    win_wdata, win_rdata;
  logic                          sums_we;
  logic [imsi_pkg::SUMS_W-1:0]   sums_wdata, sums_rdata;

  // Combinational helpers.
  logic [imsi_pkg::FILL_W:0]           slot_sum;
  logic signed [15:0]                  cv;
  logic                                ingest;
  logic signed [imsi_pkg::SUM_W-1:0]   new_sum;
  logic [imsi_pkg::SQ_W-1:0]           new_sq;
  logic signed [imsi_pkg::MUL_P_W-1:0] lhs;
  logic [31:0]                         thr_sel;
  logic signed [32:0]                  ang_r;
  logic signed [XW-1:0]                ang_sum;
  logic signed [VW:0]                  vel_r;
  logic signed [XW-1:0]                vel_sum;
  logic signed [VW-1:0]                vnew;
  logic signed [VW:0]                  vhi;
  logic [33:0]                         lo_sum;
  logic signed [XW-1:0]                disp_sum;
  logic                                out_free, seg_on, out_load;
  logic [imsi_pkg::CH_W-1:0]           rate_ch;

  assign pready   = 1'b1;
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign seg_on   = moving || active;
  assign rate_ch  = imsi_pkg::CH_W'(ax) + imsi_pkg::CH_W'(3);
  assign out_load = out_free && (((state == S_D_CLOSE) && active && !moving) ||
                                 (state == S_TOT));

  always_comb begin
    unique case (imsi_pkg::reg_idx_t'(paddr[3:2]))
      imsi_pkg::REG_ACC_THR:  prdata = acc_thr;
      imsi_pkg::REG_GYRO_THR: prdata = gyro_thr;
      imsi_pkg::REG_PERIOD:   prdata = {16'd0, period};
      imsi_pkg::REG_GRAVITY:  prdata = {16'd0, gravity};
      default:                prdata = 32'd0;
    endcase
  end

  // Window write happens at acceptance, at the slot after the newest sample.
  always_comb begin
    slot_sum = (imsi_pkg::FILL_W + 1)'(head) + (imsi_pkg::FILL_W + 1)'(fill);
    if (slot_sum >= (imsi_pkg::FILL_W + 1)'(imsi_pkg::WINDOW_LEN)) begin
      win_waddr = imsi_pkg::WIN_AW'(slot_sum - (imsi_pkg::FILL_W + 1)'(imsi_pkg::WINDOW_LEN));
    end else begin
      win_waddr = imsi_pkg::WIN_AW'(slot_sum);
    end
    win_we    = in_valid && in_ready;
    win_wdata = {yaw_rate, roll_rate, pitch_rate, acc_z, acc_y, acc_x};
  end

  always_comb begin
    ingest  = (state == S_I_SQ) || (state == S_I_WR);
    cv      = ingest ? vin[ch] : xs[ch];
    if (ingest) begin
      new_sum = cur_sum + imsi_pkg::SUM_W'(cv);
      new_sq  = cur_sq + mul_p[imsi_pkg::SQ_W-1:0];
    end else begin
      new_sum = cur_sum - imsi_pkg::SUM_W'(cv);
      new_sq  = cur_sq - mul_p[imsi_pkg::SQ_W-1:0];
    end
    sums_we    = (state == S_I_WR) || (state == S_C_WB);
    sums_wdata = {new_sum, new_sq};
    lhs        = t_nsq - t_ssq;
    thr_sel    = (ch < imsi_pkg::CH_W'(3)) ? acc_thr : gyro_thr;

    ang_r    = 33'($signed(mul_p[31:0])) + 33'sd8;
    ang_sum  = XW'(angle[ax]) + XW'(ang_r >>> 4);
    vel_r    = (VW + 1)'($signed(mul_p[VW-1:0])) + (VW + 1)'(32768);
    vel_sum  = XW'(vel[ax]) + XW'(vel_r >>> 16);
    vnew     = sat48(vel_sum);
    vhi      = vsum >>> 17;
    lo_sum   = mul_p[33:0] + 34'h10000;
    disp_sum = XW'(disp[ax]) + XW'(hi_p) + XW'(lo_sum[33:17]);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_D_RD: begin
        mul_a = imsi_pkg::MUL_A_W'(fill);
        mul_b = imsi_pkg::MUL_B_W'(fill - 1'b1);
      end
      S_C_SS: begin
        // The sum is squared straight from the RAM while it is registered.
        mul_a = imsi_pkg::MUL_A_W'($signed(sums_rdata[imsi_pkg::SUMS_W-1:imsi_pkg::SQ_W]));
        mul_b = $signed(sums_rdata[imsi_pkg::SUMS_W-1:imsi_pkg::SQ_W]);
      end
      S_C_NQ: begin
        mul_a = imsi_pkg::MUL_A_W'(cur_sq);
        mul_b = imsi_pkg::MUL_B_W'(fill);
      end
      S_C_TH: begin
        mul_a = imsi_pkg::MUL_A_W'(thr_sel);
        mul_b = imsi_pkg::MUL_B_W'(nn);
      end
      S_I_SQ, S_C_XX: begin
        mul_a = imsi_pkg::MUL_A_W'(cv);
        mul_b = imsi_pkg::MUL_B_W'(cv);
      end
      S_G_ANG: begin
        mul_a = imsi_pkg::MUL_A_W'(xs[rate_ch]);
        mul_b = imsi_pkg::MUL_B_W'(period);
      end
      S_G_ACC: begin
        mul_a = imsi_pkg::MUL_A_W'(xs[imsi_pkg::CH_W'(ax)]);
        mul_b = imsi_pkg::MUL_B_W'(gravity);
      end
      S_G_ADT: begin
        mul_a = imsi_pkg::MUL_A_W'($signed(mul_p[32:0]));
        mul_b = imsi_pkg::MUL_B_W'(period);
      end
      S_G_HI: begin
        mul_a = imsi_pkg::MUL_A_W'(vhi);
        mul_b = imsi_pkg::MUL_B_W'(period);
      end
      S_G_LO: begin
        mul_a = imsi_pkg::MUL_A_W'(vsum[16:0]);
        mul_b = imsi_pkg::MUL_B_W'(period);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;

    if (rst) begin
      acc_thr   <= imsi_pkg::ACC_THR_RESET;
      gyro_thr  <= imsi_pkg::GYRO_THR_RESET;
      period    <= imsi_pkg::PERIOD_RESET;
      gravity   <= imsi_pkg::GRAVITY_RESET;
      state     <= S_IDLE;
      ch        <= '0;
      ax        <= '0;
      fill      <= '0;
      head      <= '0;
      counter   <= '0;
      seg_begin <= '0;
      active    <= 1'b0;
      moving    <= 1'b0;
      fin       <= 1'b0;
      sum_vld   <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        angle[i] <= '0;
        vel[i]   <= '0;
        disp[i]  <= '0;
      end
      for (int i = 0; i < imsi_pkg::NCH; i++) begin
        grand[i] <= '0;
      end
    end else begin
      if (psel && penable && pwrite) begin
        unique case (imsi_pkg::reg_idx_t'(paddr[3:2]))
          imsi_pkg::REG_ACC_THR:  acc_thr  <= pwdata;
          imsi_pkg::REG_GYRO_THR: gyro_thr <= pwdata;
          imsi_pkg::REG_PERIOD:   period   <= pwdata[15:0];
          imsi_pkg::REG_GRAVITY:  gravity  <= pwdata[15:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            vin[0] <= acc_x;
            vin[1] <= acc_y;
            vin[2] <= acc_z;
            vin[3] <= pitch_rate;
            vin[4] <= roll_rate;
            vin[5] <= yaw_rate;
            fin    <= final_sample;
            fill   <= fill + 1'b1;
            ch     <= '0;
            state  <= S_I_RD;
          end
        end
        S_I_RD: state <= S_I_SQ;
        S_I_SQ: begin
          cur_sum <= sum_vld[ch] ? $signed(sums_rdata[imsi_pkg::SUMS_W-1:imsi_pkg::SQ_W]) : '0;
          cur_sq  <= sum_vld[ch] ? sums_rdata[imsi_pkg::SQ_W-1:0] : '0;
          state   <= S_I_WR;
        end
        S_I_WR: begin
          sum_vld[ch] <= 1'b1;
          if (ch == imsi_pkg::CH_W'(imsi_pkg::NCH - 1)) begin
            if (fin || fill == imsi_pkg::FILL_W'(imsi_pkg::WINDOW_LEN)) begin
              state <= S_D_RD;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            ch    <= ch + 1'b1;
            state <= S_I_RD;
          end
        end
        S_D_RD: state <= S_D_X;
        S_D_X: begin
          for (int i = 0; i < imsi_pkg::NCH; i++) begin
            xs[i] <= $signed(win_rdata[16*i +: 16]);
          end
          nn     <= mul_p[imsi_pkg::NN_W-1:0];
          moving <= 1'b0;
          ch     <= '0;
          state  <= S_C_RD;
        end
        S_C_RD: state <= S_C_SS;
        S_C_SS: begin
          cur_sum <= $signed(sums_rdata[imsi_pkg::SUMS_W-1:imsi_pkg::SQ_W]);
          cur_sq  <= sums_rdata[imsi_pkg::SQ_W-1:0];
          state   <= S_C_NQ;
        end
        S_C_NQ: begin
          t_ssq <= mul_p;
          state <= S_C_TH;
        end
        S_C_TH: begin
          t_nsq <= mul_p;
          state <= S_C_XX;
        end
        S_C_XX: begin
          // A window of a single sample has no variance and counts as still.
          if (fill >= imsi_pkg::FILL_W'(2) && lhs > mul_p) begin
            moving <= 1'b1;
          end
          state <= S_C_WB;
        end
        S_C_WB: begin
          if (ch == imsi_pkg::CH_W'(imsi_pkg::NCH - 1)) begin
            state <= S_D_SEG;
          end else begin
            ch    <= ch + 1'b1;
            state <= S_C_RD;
          end
        end
        S_D_SEG: begin
          if (moving && !active) begin
            active    <= 1'b1;
            seg_begin <= counter;
            for (int i = 0; i < 3; i++) begin
              angle[i] <= '0;
              vel[i]   <= '0;
              disp[i]  <= '0;
            end
          end
          ax    <= '0;
          state <= seg_on ? S_G_ANG : S_D_CLOSE;
        end
        S_G_ANG: state <= S_G_ACC;
        S_G_ACC: begin
          angle[ax] <= sat48(ang_sum);
          state     <= S_G_ADT;
        end
        S_G_ADT: state <= S_G_VEL;
        S_G_VEL: begin
          vel[ax] <= vnew;
          vsum    <= (VW + 1)'(vel[ax]) + (VW + 1)'(vnew);
          state   <= S_G_HI;
        end
        S_G_HI: state <= S_G_LO;
        S_G_LO: begin
          hi_p  <= $signed(mul_p[VW-1:0]);
          state <= S_G_DSP;
        end
        S_G_DSP: begin
          disp[ax] <= sat48(disp_sum);
          if (ax == 2'd2) begin
            state <= S_D_CLOSE;
          end else begin
            ax    <= ax + 1'b1;
            state <= S_G_ANG;
          end
        end
        S_D_CLOSE: begin
          if (active && !moving) begin
            if (out_free) begin
              is_total    <= 1'b0;
              seg_start   <= seg_begin;
              seg_stop    <= counter + 1'b1;
              pitch_angle <= angle[0];
              roll_angle  <= angle[1];
              yaw_angle   <= angle[2];
              disp_x      <= disp[0];
              disp_y      <= disp[1];
              disp_z      <= disp[2];
              last_result <= !fin;
              for (int i = 0; i < 3; i++) begin
                grand[i]     <= sat48(XW'(grand[i]) + XW'(angle[i]));
                grand[3 + i] <= sat48(XW'(grand[3 + i]) + XW'(disp[i]));
                angle[i]     <= '0;
                vel[i]       <= '0;
                disp[i]      <= '0;
              end
              active <= 1'b0;
              state  <= S_D_END;
            end
          end else begin
            state <= S_D_END;
          end
        end
        S_D_END: begin
          head    <= (head == imsi_pkg::WIN_AW'(imsi_pkg::WINDOW_LEN - 1)) ? '0 : head + 1'b1;
          fill    <= fill - 1'b1;
          counter <= counter + 1'b1;
          if (!fin) begin
            state <= S_IDLE;
          end else if (fill != imsi_pkg::FILL_W'(1)) begin
            state <= S_D_RD;
          end else begin
            state <= S_TOT;
          end
        end
        S_TOT: begin
          if (out_free) begin
            is_total    <= 1'b1;
            seg_start   <= '0;
            seg_stop    <= counter;
            pitch_angle <= grand[0];
            roll_angle  <= grand[1];
            yaw_angle   <= grand[2];
            disp_x      <= grand[3];
            disp_y      <= grand[4];
            disp_z      <= grand[5];
            last_result <= 1'b1;
            // A new recording starts from empty state.
            fill      <= '0;
            head      <= '0;
            counter   <= '0;
            seg_begin <= '0;
            active    <= 1'b0;
            sum_vld   <= '0;
            for (int i = 0; i < 3; i++) begin
              angle[i] <= '0;
              vel[i]   <= '0;
              disp[i]  <= '0;
            end
            for (int i = 0; i < imsi_pkg::NCH; i++) begin
              grand[i] <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  imsi_ram #(
    .WIDTH (imsi_pkg::WIN_W),
    .DEPTH (imsi_pkg::WINDOW_LEN)
  ) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (win_waddr),
    .wdata (win_wdata),
    .raddr (head),
    .rdata (win_rdata)
  );

  imsi_ram #(
    .WIDTH (imsi_pkg::SUMS_W),
    .DEPTH (imsi_pkg::NCH)
  ) u_sums_ram (
    .clk   (clk),
    .we    (sums_we),
    .waddr (ch),
    .wdata (sums_wdata),
    .raddr (ch),
    .rdata (sums_rdata)
  );

endmodule

// ----- sim/imu_motion_segment_integrator_tb.sv -----
// Self-checking testbench for the IMU motion segment integrator.
module imu_motion_segment_integrator_tb;

  localparam int  CYCLE_LIMIT  = 1500000;
  localparam int  SETTLE_CYCLES = 1200;
  localparam int  MAX_REPORTS  = 10;

  typedef struct packed {
    logic            total;
    logic [23:0]     start;
    logic [23:0]     stop;
    logic [5:0][47:0] val;
    logic            last;
  } seg_result_t;

  typedef logic [5:0][15:0] imu_sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [imsi_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] acc_x = '0, acc_y = '0, acc_z = '0;
  logic signed [15:0] pitch_rate = '0, roll_rate = '0, yaw_rate = '0;
  logic final_sample = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic is_total, last_result;
  logic [imsi_pkg::IDX_W-1:0] seg_start, seg_stop;
  logic signed [imsi_pkg::VAL_W-1:0] pitch_angle, roll_angle, yaw_angle;
  logic signed [imsi_pkg::VAL_W-1:0] disp_x, disp_y, disp_z;

  imu_motion_segment_integrator i_dut (.*);

  always #5 clk = ~clk;

  // Shadow of the configuration registers.
  longint acc_thr, gyro_thr, period, gravity;

  // Shadow of the recording state.
  longint win_buf [imsi_pkg::WINDOW_LEN][6];
  int     win_head, win_fill;
  longint ch_sum [6], ch_sqsum [6];
  longint sample_idx, seg_first;
  bit     seg_open;
  longint angle [3], velocity [3], displacement [3], totals [6];

  seg_result_t expected_q [$];
  seg_result_t step_q [$];

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int errors = 0;
  int cycles = 0;

  function automatic longint sat48(longint x);
    if (x > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
    if (x < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
    return x;
  endfunction

  function automatic void clear_segment();
    for (int c = 0; c < 3; c++) begin
      angle[c] = 0;
      velocity[c] = 0;
      displacement[c] = 0;
    end
  endfunction

  function automatic void clear_recording();
    win_head = 0;
    win_fill = 0;
    for (int c = 0; c < 6; c++) begin
      ch_sum[c] = 0;
      ch_sqsum[c] = 0;
      totals[c] = 0;
    end
    sample_idx = 0;
    seg_first = 0;
    seg_open = 0;
    clear_segment();
  endfunction

  function automatic void queue_result(bit total, longint start, longint stop,
                                       longint v [6]);
    seg_result_t r;
    r.total = total;
    r.start = start[23:0];
    r.stop  = stop[23:0];
    for (int c = 0; c < 6; c++) r.val[c] = v[c][47:0];
    r.last = 1'b0;
    step_q.push_back(r);
  endfunction

  function automatic void integrate_sample(int slot);
    longint u, v, s, hi, lo;
    for (int c = 0; c < 3; c++) begin
      angle[c] = sat48(angle[c] + ((win_buf[slot][3+c] * period + 8) >>> 4));
      u = velocity[c];
      v = sat48(u + ((win_buf[slot][c] * gravity * period + 32768) >>> 16));
      s = u + v;
      hi = s >>> 17;
      lo = s - (hi <<< 17);
      displacement[c] = sat48(displacement[c] + hi * period +
                              ((lo * period + 65536) >>> 17));
      velocity[c] = v;
    end
  endfunction

  // Decides the oldest held sample against the window that starts with it.
  function automatic void decide_oldest();
    longint n, lhs, thr;
    longint v [6];
    bit moving;
    n = win_fill;
    moving = 0;
    if (n >= 2) begin
      for (int c = 0; c < 6; c++) begin
        lhs = n * ch_sqsum[c] - ch_sum[c] * ch_sum[c];
        thr = (c < 3) ? acc_thr : gyro_thr;
        if (lhs > thr * n * (n - 1)) moving = 1;
      end
    end
    if (moving && !seg_open) begin
      seg_open = 1;
      seg_first = sample_idx;
      clear_segment();
    end
    if (seg_open) integrate_sample(win_head);
    if (!moving && seg_open) begin
      for (int c = 0; c < 3; c++) begin
        v[c] = angle[c];
        v[3+c] = displacement[c];
      end
      for (int c = 0; c < 6; c++) totals[c] = sat48(totals[c] + v[c]);
      queue_result(0, seg_first, sample_idx + 1, v);
      seg_open = 0;
      clear_segment();
    end
    for (int c = 0; c < 6; c++) begin
      ch_sum[c] -= win_buf[win_head][c];
      ch_sqsum[c] -= win_buf[win_head][c] * win_buf[win_head][c];
    end
    win_head = (win_head + 1) % imsi_pkg::WINDOW_LEN;
    win_fill--;
    sample_idx = (sample_idx + 1) & 24'hFFFFFF;
  endfunction

  function automatic void predict_sample(imu_sample_t s, bit fin);
    int slot;
    longint x;
    seg_result_t r;
    slot = (win_head + win_fill) % imsi_pkg::WINDOW_LEN;
    for (int c = 0; c < 6; c++) begin
      x = longint'($signed(s[c]));
      win_buf[slot][c] = x;
      ch_sum[c] += x;
      ch_sqsum[c] += x * x;
    end
    win_fill++;
    if (!fin) begin
      if (win_fill >= imsi_pkg::WINDOW_LEN) decide_oldest();
    end else begin
      while (win_fill > 0) decide_oldest();
      queue_result(1, 0, sample_idx, totals);
      clear_recording();
    end
    if (step_q.size() > 0) step_q[$].last = 1'b1;
    while (step_q.size() > 0) begin
      r = step_q.pop_front();
      expected_q.push_back(r);
    end
  endfunction

  task automatic reg_write(imsi_pkg::reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= imsi_pkg::PADDR_W'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      imsi_pkg::REG_ACC_THR:  acc_thr = value;
      imsi_pkg::REG_GYRO_THR: gyro_thr = value;
      imsi_pkg::REG_PERIOD:   period = value[15:0];
      imsi_pkg::REG_GRAVITY:  gravity = value[15:0];
    endcase
  endtask

  task automatic set_config(logic [31:0] athr, logic [31:0] gthr,
                            logic [15:0] dt, logic [15:0] grav);
    reg_write(imsi_pkg::REG_ACC_THR, athr);
    reg_write(imsi_pkg::REG_GYRO_THR, gthr);
    reg_write(imsi_pkg::REG_PERIOD, {16'd0, dt});
    reg_write(imsi_pkg::REG_GRAVITY, {16'd0, grav});
  endtask

  task automatic send_sample(imu_sample_t s, bit fin);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    acc_x <= s[0];
    acc_y <= s[1];
    acc_z <= s[2];
    pitch_rate <= s[3];
    roll_rate <= s[4];
    yaw_rate <= s[5];
    final_sample <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_sample(s, fin);
  endtask

  // Waits for every expected result, then lets the block finish any
  // decision that produces no result.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic imu_sample_t all_channels(logic [15:0] v);
    imu_sample_t s;
    for (int c = 0; c < 6; c++) s[c] = v;
    return s;
  endfunction

  function automatic imu_sample_t random_sample();
    imu_sample_t s;
    for (int c = 0; c < 6; c++) s[c] = 16'($urandom());
    return s;
  endfunction

  // One recording made of still stretches and bursts of motion, then final.
  task automatic send_recording(int len);
    imu_sample_t base, s;
    int sent, run, kind;
    sent = 0;
    while (sent < len - 1) begin
      kind = $urandom_range(0, 3);
      run = (kind == 0) ? $urandom_range(11, 20) : $urandom_range(1, 8);
      base = random_sample();
      for (int k = 0; k < run && sent < len - 1; k++) begin
        case (kind)
          0: for (int c = 0; c < 6; c++)
               s[c] = base[c] + 16'($signed($urandom_range(0, 4)) - 2);
          1: s = random_sample();
          default: for (int c = 0; c < 6; c++)
               s[c] = base[c] + 16'($signed($urandom_range(0, 2000)) - 1000);
        endcase
        send_sample(s, 0);
        sent++;
      end
    end
    send_sample(random_sample(), 1);
  endtask

  task automatic random_config();
    logic [31:0] athr, gthr;
    case ($urandom_range(0, 3))
      0: athr = 0;
      1: athr = 32'hFFFF_FFFF;
      default: athr = $urandom_range(0, 200000);
    endcase
    gthr = ($urandom_range(0, 3) == 0) ? 32'($urandom()) : $urandom_range(0, 2000000);
    set_config(athr, gthr, 16'($urandom_range(1, 65535)), 16'($urandom()));
  endtask

  task automatic test_directed();
    imu_sample_t s;
    set_config(imsi_pkg::ACC_THR_RESET, imsi_pkg::GYRO_THR_RESET,
               imsi_pkg::PERIOD_RESET, imsi_pkg::GRAVITY_RESET);
    for (int k = 0; k < 6; k++) send_sample(all_channels(16'h0000), 0);
    send_sample(all_channels(16'h7FFF), 0);
    send_sample(all_channels(16'h8000), 0);
    send_sample(all_channels(16'h7FFF), 0);
    send_sample(all_channels(16'hFFFF), 0);
    for (int c = 0; c < 6; c++) s[c] = (c % 2) ? 16'h8000 : 16'h7FFF;
    send_sample(s, 0);
    for (int k = 0; k < 11; k++) send_sample(all_channels(16'h1000), 0);
    send_sample(all_channels(16'h8000), 1);
    // A recording of a single sample, then one of two.
    send_sample(all_channels(16'h7FFF), 1);
    send_sample(all_channels(16'h8000), 0);
    send_sample(all_channels(16'h7FFF), 1);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    set_config(32'd0, 32'd0, 16'd1, 16'd0);
    send_recording(10);
    wait_idle();
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_recording(10);
    wait_idle();
  endtask

  // Full-scale samples with the largest period and gravity drive the
  // accumulators and the grand totals to large values of both signs.
  task automatic test_large_values();
    imu_sample_t s;
    set_config(32'd0, 32'd0, 16'hFFFF, 16'hFFFF);
    for (int k = 0; k < 16; k++) begin
      s = all_channels(k < 8 ? 16'h7FFF : 16'h8000);
      for (int c = 3; c < 6; c++) s[c] = k[0] ? 16'h7FFF : 16'h8000;
      send_sample(s, 0);
    end
    for (int k = 0; k < 12; k++) send_sample(all_channels(16'h0000), 0);
    send_sample(all_channels(16'h0000), 1);
    wait_idle();
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int nitems);
    int sent, len;
    sender_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    random_config();
    sent = 0;
    while (sent < nitems) begin
      len = $urandom_range(1, 16);
      send_recording(len);
      sent += len;
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    set_config(32'd0, 32'd0, imsi_pkg::PERIOD_RESET, imsi_pkg::GRAVITY_RESET);
    hold_cycles = 4000;
    send_recording(20);
    send_recording(3);
    wait_idle();
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(string name, logic [47:0] exp_v, logic [47:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("mismatch %s: expected %h, got %h", name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    seg_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $display("unexpected result at cycle %0d", cycles);
      end else begin
        e = expected_q.pop_front();
        check_field("is_total", e.total, is_total);
        check_field("seg_start", e.start, seg_start);
        check_field("seg_stop", e.stop, seg_stop);
        check_field("pitch_angle", e.val[0], pitch_angle);
        check_field("roll_angle", e.val[1], roll_angle);
        check_field("yaw_angle", e.val[2], yaw_angle);
        check_field("disp_x", e.val[3], disp_x);
        check_field("disp_y", e.val[4], disp_y);
        check_field("disp_z", e.val[5], disp_z);
        check_field("last_result", e.last, last_result);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    acc_thr = imsi_pkg::ACC_THR_RESET;
    gyro_thr = imsi_pkg::GYRO_THR_RESET;
    period = imsi_pkg::PERIOD_RESET;
    gravity = imsi_pkg::GRAVITY_RESET;
    clear_recording();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_large_values();
    test_random_phase(0, 0, 10);
    test_random_phase(78, 0, 10);
    test_random_phase(0, 78, 10);
    test_random_phase(36, 36, 10);
    test_backpressure();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
